>>> design/sai_pkg.sv
// ----------------------------------------------------------------------------
// sai_pkg
// shared types and constants of the sorted array insert unit
// ----------------------------------------------------------------------------
package sai_pkg;

  localparam int unsigned TableDepthDefault = 64;
  localparam int unsigned ValueW            = 32;
  localparam int unsigned ReadIndexW        = 6;
  localparam int unsigned EntryCountW       = 7;
  localparam int unsigned StatusW           = 2;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_READ   = 1'b1
  } sai_op_e;

  typedef enum logic [StatusW-1:0] {
    STATUS_OK        = 2'd0,
    STATUS_FULL      = 2'd1,
    STATUS_BAD_INDEX = 2'd2
  } sai_status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_WALK,
    S_PLACE,
    S_DONE
  } sai_state_e;

endpackage

>>> design/sai_if.sv
// ----------------------------------------------------------------------------
// sai_in_if / sai_out_if
// valid/ready channels of the sorted array insert unit
// ----------------------------------------------------------------------------
interface sai_in_if;
  import sai_pkg::*;

  logic                         valid;
  logic                         ready;
  logic                         opcode;
  logic signed [ValueW-1:0]     value;
  logic        [ReadIndexW-1:0] read_index;

  modport source (output valid, opcode, value, read_index, input ready);
  modport sink   (input valid, opcode, value, read_index, output ready);
endinterface

interface sai_out_if;
  import sai_pkg::*;

  logic                          valid;
  logic                          ready;
  logic signed [ValueW-1:0]      read_value;
  logic        [EntryCountW-1:0] entry_count;
  logic        [StatusW-1:0]     status;

  modport source (output valid, read_value, entry_count, status, input ready);
  modport sink   (input valid, read_value, entry_count, status, output ready);
endinterface

>>> design/sai_store.sv
// ----------------------------------------------------------------------------
// sai_store
// single write port, single read port memory with registered read data
// ----------------------------------------------------------------------------
module sai_store #(
  parameter int unsigned Depth = sai_pkg::TableDepthDefault,
  parameter int unsigned Width = sai_pkg::ValueW
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/sorted_array_insert_unit.sv
// ----------------------------------------------------------------------------
// sorted_array_insert_unit
// ascending table of signed 32-bit values with ordered insert and indexed read
// ----------------------------------------------------------------------------
// Items arrive on in_i (opcode, value, read_index) and each one gives exactly
// one beat on out_o (read_value, entry_count, status). Both are valid/ready.
// A read of an index below the fill count goes through S_READ and S_DONE to
// the output register; a bad index, a full-table insert or an insert into an
// empty table goes from accept straight to S_DONE. An insert walks the memory
// from the top entry down, one entry per cycle, moving each larger entry up
// one place until it finds the slot. The single read port of the table
// memory, with its registered read data, sets this pace.
// One item is in work at a time; in_i.ready is high only when idle. The
// result sits in an output register, so the next item is taken while the
// last result still waits on a stalled receiver; the unit only holds off
// once a second result is ready and the register is still full.
// Reset empties the table by clearing the fill count; entries at or above
// the count are never read, so the memory needs no clearing pass.
// ----------------------------------------------------------------------------
module sorted_array_insert_unit #(
  parameter int unsigned TableDepth = sai_pkg::TableDepthDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  sai_in_if.sink     in_i,
  sai_out_if.source  out_o
);
  import sai_pkg::*;

  localparam int unsigned IdxW = $clog2(TableDepth);
  localparam int unsigned CntW = $clog2(TableDepth + 1);
  localparam int unsigned CmpW = (CntW > ReadIndexW) ? CntW : ReadIndexW;

  sai_state_e state_q, state_d;

  logic signed [ValueW-1:0] val_q, val_d;
  logic [IdxW-1:0]          ptr_q, ptr_d;
  logic [CntW-1:0]          cnt_q, cnt_d;
  logic signed [ValueW-1:0] res_val_q, res_val_d;
  sai_status_e              res_st_q, res_st_d;

  logic                      out_valid_q, out_valid_d;
  logic signed [ValueW-1:0]  out_val_q, out_val_d;
  logic [EntryCountW-1:0]    out_cnt_q, out_cnt_d;
  sai_status_e               out_st_q, out_st_d;

  logic                     we;
  logic [IdxW-1:0]          waddr;
  logic [ValueW-1:0]        wdata;
  logic [IdxW-1:0]          raddr;
  logic [ValueW-1:0]        rdata;
  logic signed [ValueW-1:0] rdata_s;

  logic                     accept;
  logic                     out_free;
  logic [CmpW-1:0]          idx_ext;
  logic [CmpW-1:0]          cnt_ext;

  sai_store #(
    .Depth (TableDepth),
    .Width (ValueW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign rdata_s  = $signed(rdata);
  assign accept   = in_i.valid && in_i.ready;
  assign out_free = !out_valid_q || out_o.ready;
  assign idx_ext  = CmpW'(in_i.read_index);
  assign cnt_ext  = CmpW'(cnt_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q     <= val_d;
    ptr_q     <= ptr_d;
    res_val_q <= res_val_d;
    res_st_q  <= res_st_d;
    out_val_q <= out_val_d;
    out_cnt_q <= out_cnt_d;
    out_st_q  <= out_st_d;
  end

  always_comb begin
    state_d     = state_q;
    val_d       = val_q;
    ptr_d       = ptr_q;
    cnt_d       = cnt_q;
    res_val_d   = res_val_q;
    res_st_d    = res_st_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_val_d   = out_val_q;
    out_cnt_d   = out_cnt_q;
    out_st_d    = out_st_q;
    we          = 1'b0;
    waddr       = ptr_q + 1'b1;
    wdata       = val_q;
    raddr       = ptr_q;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          val_d = in_i.value;
          if (sai_op_e'(in_i.opcode) == OP_READ) begin
            if (idx_ext < cnt_ext) begin
              raddr   = IdxW'(in_i.read_index);
              state_d = S_READ;
            end else begin
              res_val_d = '0;
              res_st_d  = STATUS_BAD_INDEX;
              state_d   = S_DONE;
            end
          end else begin
            res_val_d = in_i.value;
            if (cnt_q == CntW'(TableDepth)) begin
              res_st_d = STATUS_FULL;
              state_d  = S_DONE;
            end else if (cnt_q == '0) begin
              we       = 1'b1;
              waddr    = '0;
              wdata    = in_i.value;
              cnt_d    = cnt_q + 1'b1;
              res_st_d = STATUS_OK;
              state_d  = S_DONE;
            end else begin
              // start the walk at the top entry
              ptr_d    = IdxW'(cnt_q - 1'b1);
              raddr    = IdxW'(cnt_q - 1'b1);
              res_st_d = STATUS_OK;
              state_d  = S_WALK;
            end
          end
        end
      end

      S_READ: begin
        res_val_d = rdata_s;
        res_st_d  = STATUS_OK;
        state_d   = S_DONE;
      end

      S_WALK: begin
        we    = 1'b1;
        waddr = ptr_q + 1'b1;
        if (rdata_s > val_q) begin
          // entry moves up, keep walking down
          wdata = rdata;
          if (ptr_q == '0) begin
            state_d = S_PLACE;
          end else begin
            ptr_d = ptr_q - 1'b1;
            raddr = ptr_q - 1'b1;
          end
        end else begin
          // slot found just above an entry less than or equal to the value
          wdata   = val_q;
          cnt_d   = cnt_q + 1'b1;
          state_d = S_DONE;
        end
      end

      S_PLACE: begin
        we      = 1'b1;
        waddr   = '0;
        wdata   = val_q;
        cnt_d   = cnt_q + 1'b1;
        state_d = S_DONE;
      end

      S_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_val_d   = res_val_q;
          out_cnt_d   = EntryCountW'(cnt_q);
          out_st_d    = res_st_q;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign in_i.ready        = (state_q == S_IDLE);
  assign out_o.valid       = out_valid_q;
  assign out_o.read_value  = out_val_q;
  assign out_o.entry_count = out_cnt_q;
  assign out_o.status      = out_st_q;

endmodule

>>> design/sai_checker.sv
// ----------------------------------------------------------------------------
// sai_checker
// port-level checks of the sorted array insert unit, bound to the top level
// ----------------------------------------------------------------------------
module sai_checker #(
  parameter int unsigned TableDepth = sai_pkg::TableDepthDefault
) (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               in_valid_i,
  input logic                               in_ready_i,
  input logic                               out_valid_i,
  input logic                               out_ready_i,
  input logic signed [sai_pkg::ValueW-1:0]  read_value_i,
  input logic [sai_pkg::EntryCountW-1:0]    entry_count_i,
  input logic [sai_pkg::StatusW-1:0]        status_i
);
  import sai_pkg::*;

  // one item in work at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |=> !in_ready_i)
    else $error("input taken while an item is still in work");

  // a held result beat must not change
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=>
      (out_valid_i && $stable(read_value_i) && $stable(entry_count_i)
       && $stable(status_i)))
    else $error("stalled result beat changed");

  // a dropped insert only happens on a full table
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && status_i == STATUS_FULL) |->
      (entry_count_i == EntryCountW'(TableDepth)))
    else $error("full status with a table that is not full");

  // a bad index read returns zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && status_i == STATUS_BAD_INDEX) |-> (read_value_i == '0))
    else $error("bad index read returned data");

endmodule

bind sorted_array_insert_unit sai_checker #(
  .TableDepth (TableDepth)
) u_sai_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .read_value_i  (out_o.read_value),
  .entry_count_i (out_o.entry_count),
  .status_i      (out_o.status)
);

>>> test/sorted_array_insert_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_array_insert_unit_test
// self-checking bench for the sorted array insert unit
// ----------------------------------------------------------------------------
// A shadow copy of the table predicts every reply: ordered inserts with equal
// values kept in arrival order, indexed reads, the full-table drop and the
// bad-index error. A short directed run covers the corner values, then random
// traffic fills the table and keeps reading and inserting once it is full.
// Both channels idle in random bursts except near the end of the run.
// ----------------------------------------------------------------------------
module sorted_array_insert_unit_test;
  import sai_pkg::*;

  localparam int unsigned Depth     = TableDepthDefault;
  localparam int unsigned ItemCount = 500;
  localparam int unsigned QuietTail = 60;
  localparam int unsigned MaxShown  = 10;

  typedef struct {
    logic signed [ValueW-1:0]      read_value;
    logic        [EntryCountW-1:0] entry_count;
    logic        [StatusW-1:0]     status;
  } table_reply_t;

  class sorted_table_scoreboard;
    logic signed [ValueW-1:0] shadow_table [Depth];
    int unsigned              fill_level;
    table_reply_t             pending_replies [$];
    int unsigned              mismatches;

    function new();
      foreach (shadow_table[i]) shadow_table[i] = '0;
      fill_level = 0;
      mismatches = 0;
    endfunction

    function void report(string msg);
      mismatches++;
      if (mismatches <= MaxShown) $display("%s", msg);
    endfunction

    // work out the reply of an accepted beat and update the shadow table
    function void note_item(sai_op_e op, logic signed [ValueW-1:0] value,
                            logic [ReadIndexW-1:0] index);
      table_reply_t reply;
      int unsigned  slot;
      reply.read_value = '0;
      reply.status     = STATUS_OK;
      if (op == OP_INSERT) begin
        reply.read_value = value;
        if (fill_level >= Depth) begin
          reply.status = STATUS_FULL;
        end else begin
          // new value lands after every entry less than or equal to it
          slot = 0;
          while (slot < fill_level && shadow_table[slot] <= value) slot++;
          for (int unsigned k = fill_level; k > slot; k--) begin
            shadow_table[k] = shadow_table[k-1];
          end
          shadow_table[slot] = value;
          fill_level++;
        end
      end else if (index < fill_level) begin
        reply.read_value = shadow_table[index];
      end else begin
        reply.status = STATUS_BAD_INDEX;
      end
      reply.entry_count = fill_level[EntryCountW-1:0];
      pending_replies.push_back(reply);
    endfunction

    function void check_beat(logic signed [ValueW-1:0] read_value,
                             logic [EntryCountW-1:0] entry_count,
                             logic [StatusW-1:0] status);
      table_reply_t want;
      if (pending_replies.size() == 0) begin
        report($sformatf("unexpected reply: value %0d count %0d status %0d",
                         read_value, entry_count, status));
        return;
      end
      want = pending_replies.pop_front();
      if (read_value !== want.read_value || entry_count !== want.entry_count ||
          status !== want.status) begin
        report($sformatf({"reply mismatch: expected value %0d count %0d status %0d,",
                          " got value %0d count %0d status %0d"},
                         want.read_value, want.entry_count, want.status,
                         read_value, entry_count, status));
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  bit   idling_on;

  sai_in_if  in_bus ();
  sai_out_if out_bus ();

  sorted_array_insert_unit #(
    .TableDepth (Depth)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  sorted_table_scoreboard sb;

  always #10 clk_i = ~clk_i;

  // drive one beat, with an optional idle burst ahead of it
  task automatic send_item(input sai_op_e op, input logic signed [ValueW-1:0] value,
                           input logic [ReadIndexW-1:0] index);
    if (idling_on && $urandom_range(0, 3) == 0) begin
      in_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    in_bus.valid      <= 1'b1;
    in_bus.opcode     <= op;
    in_bus.value      <= value;
    in_bus.read_index <= index;
    @(posedge clk_i);
    while (!in_bus.ready) @(posedge clk_i);
    sb.note_item(op, value, index);
  endtask

  function automatic logic signed [ValueW-1:0] pick_value();
    int unsigned kind;
    kind = $urandom_range(0, 99);
    if (kind < 25) begin
      // narrow range so equal values pile up
      return ValueW'($signed($urandom_range(0, 8)) - 4);
    end else if (kind < 35) begin
      case ($urandom_range(0, 3))
        0:       return 32'sh8000_0000;
        1:       return 32'sh7fff_ffff;
        2:       return 32'sh0000_0000;
        default: return -32'sd1;
      endcase
    end
    return $urandom();
  endfunction

  initial begin
    sai_op_e               op;
    logic [ReadIndexW-1:0] index;
    sb                = new();
    idling_on         = 1'b1;
    rst_ni            = 1'b0;
    in_bus.valid      = 1'b0;
    in_bus.opcode     = OP_INSERT;
    in_bus.value      = '0;
    in_bus.read_index = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty table: both index extremes are out of range
    send_item(OP_READ, 32'sh1234_5678, 6'd0);
    send_item(OP_READ, -32'sd1, 6'd63);
    // first insert into an empty table, then appends and an equal-to-last
    send_item(OP_INSERT, 32'sh0000_0000, 6'd63);
    send_item(OP_INSERT, 32'sh7fff_ffff, 6'd0);
    send_item(OP_INSERT, 32'sh7fff_ffff, 6'd21);
    // below every entry, then middle inserts and a duplicate of zero
    send_item(OP_INSERT, 32'sh8000_0000, 6'd42);
    send_item(OP_INSERT, -32'sd1, 6'd0);
    send_item(OP_INSERT, 32'sh0000_0000, 6'd0);
    send_item(OP_INSERT, 32'sh0000_0005, 6'd0);
    for (int i = 0; i < 7; i++) send_item(OP_READ, 32'sh5555_aaaa, 6'(i));
    // just at and far beyond the count
    send_item(OP_READ, 32'sh0, 6'd7);
    send_item(OP_READ, 32'sh0, 6'd63);

    for (int n = 0; n < ItemCount; n++) begin
      if (n == ItemCount - QuietTail) idling_on = 1'b0;
      if (sb.fill_level < Depth) begin
        op = ($urandom_range(0, 2) == 0) ? OP_INSERT : OP_READ;
      end else begin
        op = ($urandom_range(0, 9) < 3) ? OP_INSERT : OP_READ;
      end
      if (sb.fill_level > 0 && $urandom_range(0, 4) != 0) begin
        index = ReadIndexW'($urandom_range(0, sb.fill_level - 1));
      end else begin
        index = ReadIndexW'($urandom_range(0, 63));
      end
      send_item(op, pick_value(), index);
    end
    in_bus.valid <= 1'b0;

    while (sb.pending_replies.size() != 0) @(posedge clk_i);
    repeat (Depth + 8) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending_replies.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // result side: check every beat, stall in random bursts
  initial begin
    int unsigned stall_left;
    stall_left    = 0;
    out_bus.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_bus.valid && out_bus.ready) begin
        sb.check_beat(out_bus.read_value, out_bus.entry_count, out_bus.status);
      end
      if (stall_left != 0) begin
        stall_left--;
      end else if (idling_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 5);
      end
      out_bus.ready <= (stall_left == 0);
    end
  end

  initial begin
    #10_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

>>> files.f
design/sai_pkg.sv
design/sai_if.sv
design/sai_store.sv
design/sorted_array_insert_unit.sv
design/sai_checker.sv
test/sorted_array_insert_unit_test.sv
